### hw/rtl/mhcc_pkg.sv
`timescale 1ns / 1ps

package mhcc_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int STORE_DEPTH = 1 << INDEX_BITS;
  localparam int TAG_W       = 8;
  localparam int SHIFT_W     = 6;
  localparam int SHOFF_W     = 5;

  // Shifts below this are saturated so that the index always fits the store.
  localparam logic [SHIFT_W-1:0] MIN_SHIFT  = SHIFT_W'(64 - INDEX_BITS);
  // The index is always taken from the upper half of the product.
  localparam logic [SHIFT_W-1:0] SHIFT_BASE = SHIFT_W'(32);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } mhcc_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } mhcc_ctl_t;

endpackage

### hw/rtl/mhcc_hash.sv
`timescale 1ns / 1ps

module mhcc_hash (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             kill,
  input  mhcc_pkg::mhcc_ctl_t              issue,
  input  logic [63:0]                      subset,
  input  logic [63:0]                      magic,
  input  logic [mhcc_pkg::SHOFF_W-1:0]     shift_off,
  output mhcc_pkg::mhcc_ctl_t              ctl,
  output logic [mhcc_pkg::INDEX_BITS-1:0]  idx
);
  import mhcc_pkg::*;

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [63:0] p_ll_next;
  logic [31:0] p_lh_next;
  logic [31:0] p_hl_next;
  logic [31:0] hi_sum;
  logic [31:0] hi_shifted;

  // Only the low 64 bits of the product are kept, so the two cross terms
  // contribute their low halves to the upper word alone.
  assign p_ll_next = 64'(magic[31:0]) * 64'(subset[31:0]);
  assign p_lh_next = magic[31:0] * subset[63:32];
  assign p_hl_next = magic[63:32] * subset[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= kill ? '0 : issue;
    end
    p_ll <= p_ll_next;
    p_lh <= p_lh_next;
    p_hl <= p_hl_next;
  end

  assign hi_sum     = p_ll[63:32] + p_lh + p_hl;
  assign hi_shifted = hi_sum >> shift_off;
  assign idx        = hi_shifted[INDEX_BITS-1:0];

endmodule

### hw/rtl/magic_hash_collision_check.sv
`timescale 1ns / 1ps

// After reset the block holds busy high while it clears every entry of the
// tag memory, one entry a cycle. An item is taken when start is high and
// busy is low; the block then walks the subsets of the mask at one tag
// lookup per cycle, the rate set by the one read port and one write port
// of the tag memory, and raises done for one cycle with the collision flag.
// An item makes one lookup per subset up to and including the colliding
// one, at most 4097, and busy falls together with done, so the next item
// may start in that same cycle. The result word is shown for that one cycle
// only and cannot be held off.
module magic_hash_collision_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [63:0]                   occupancy_mask,
  input  logic [63:0]                   magic_multiplier,
  input  logic [mhcc_pkg::SHIFT_W-1:0]  shift_amount,
  input  logic [mhcc_pkg::TAG_W-1:0]    epoch_tag,
  output logic                          busy,
  output logic                          done,
  output logic                          collision
);
  import mhcc_pkg::*;

  mhcc_state_t state;
  mhcc_state_t state_next;

  logic [INDEX_BITS-1:0] clear_addr;
  logic [63:0]           subset;
  logic [63:0]           subset_next;
  logic                  gen_active;
  logic [63:0]           mask;
  logic [63:0]           magic;
  logic [SHOFF_W-1:0]    shift_off;
  logic [SHIFT_W-1:0]    shift_eff;
  logic [SHIFT_W-1:0]    shift_diff;
  logic [TAG_W-1:0]      epoch;

  mhcc_ctl_t             issue;
  mhcc_ctl_t             hash_ctl;
  logic [INDEX_BITS-1:0] hash_idx;

  mhcc_ctl_t             s3_ctl;
  logic [INDEX_BITS-1:0] s3_idx;
  logic [TAG_W-1:0]      rd_data;
  logic                  fwd_valid;
  logic [INDEX_BITS-1:0] fwd_idx;

  logic                  accept;
  logic                  clearing;
  logic                  hit;
  logic                  finish;
  logic                  we;
  logic [INDEX_BITS-1:0] waddr;
  logic [TAG_W-1:0]      wdata;

  logic [TAG_W-1:0] tag_mem [STORE_DEPTH];

  assign accept   = start && !busy;
  assign clearing = (state == ST_CLEAR);

  assign shift_eff  = (shift_amount < MIN_SHIFT) ? MIN_SHIFT : shift_amount;
  assign shift_diff = shift_eff - SHIFT_BASE;

  assign subset_next = ((subset | ~mask) + 64'd1) & mask;
  assign issue.valid = gen_active;
  assign issue.last  = (subset_next == 64'd0);

  mhcc_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .kill      (hit),
    .issue     (issue),
    .subset    (subset),
    .magic     (magic),
    .shift_off (shift_off),
    .ctl       (hash_ctl),
    .idx       (hash_idx)
  );

  // The entry written in the previous cycle was read before that write
  // landed, so a match on its index is taken as a match on the epoch.
  assign hit    = s3_ctl.valid &&
                  ((rd_data == epoch) || (fwd_valid && (fwd_idx == s3_idx)));
  assign finish = s3_ctl.valid && (hit || s3_ctl.last);

  assign we    = clearing || (s3_ctl.valid && !hit);
  assign waddr = clearing ? clear_addr : s3_idx;
  assign wdata = clearing ? '0 : epoch;

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[waddr] <= wdata;
    end
    rd_data <= tag_mem[hash_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      gen_active <= 1'b0;
      s3_ctl     <= '0;
      fwd_valid  <= 1'b0;
      done       <= 1'b0;
      collision  <= 1'b0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (accept) begin
        gen_active <= 1'b1;
      end else if (hit || (gen_active && issue.last)) begin
        gen_active <= 1'b0;
      end
      s3_ctl    <= hit ? '0 : hash_ctl;
      fwd_valid <= s3_ctl.valid && !hit;
      done      <= finish;
      collision <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      subset    <= '0;
      mask      <= occupancy_mask;
      magic     <= magic_multiplier;
      shift_off <= shift_diff[SHOFF_W-1:0];
      epoch     <= epoch_tag;
    end else if (gen_active) begin
      subset <= subset_next;
    end
    s3_idx  <= hash_idx;
    fwd_idx <= s3_idx;
  end

endmodule

### hw/rtl/mhcc_checker.sv
`timescale 1ns / 1ps

module mhcc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic collision
);

  // Reset starts the clearing pass, which keeps the block busy.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low in the cycle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_collision_done: assert property (@(posedge clk) disable iff (rst)
    collision |-> done)
    else $error("collision flag outside a result word");

endmodule

bind magic_hash_collision_check mhcc_checker u_mhcc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .collision (collision)
);
